// File: rtl/stws_pkg.sv
// Package for the weighted sum tree selector: widths, codes and types.
// Used by every module in rtl/.
package stws_pkg;
   localparam int LEVELS      = 10;
   localparam int LEAVES      = 1 << LEVELS;
   localparam int WEIGHT_BITS = 32;
   localparam int SUM_BITS    = WEIGHT_BITS + LEVELS;
   localparam int IDX_BITS    = LEVELS;
   localparam int ACT_BITS    = 11;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_BEYOND = 2'd3;

   localparam logic OP_SET    = 1'b0;
   localparam logic OP_SELECT = 1'b1;

   typedef logic [SUM_BITS-1:0] sum_type;
   typedef logic [IDX_BITS-1:0] idx_type;

   // token handed from one stws_sel_cell to the next; node grows by one bit per
   // level, rest holds the leaf index bits still to be consumed by a set
   typedef struct packed {
      logic    valid;
      logic    op;
      idx_type node;
      idx_type rest;
      sum_type val;
   } tok_type;
endpackage

// File: rtl/sum_tree_weighted_selector_core.sv
// Top level of the weighted sum tree selector: control, root, chain of level cells.
// Depends on stws_pkg, stws_sel_cell, stws_level_cell.
//
// Usage: pulse start with req_ fields while busy is low. A set item writes
// a leaf weight, a select item draws a leaf weighted by the stored sums.
// One result per item appears on rsp_ for one cycle with rsp_valid high.
// Sequence: a set item reads its leaf, forms the difference, then updates
// each tree level in turn. A select item first forms the 33x42 scaling
// product in halves, then descends the tree one level at a time. A set to
// a bad index or a select on a zero total skips those steps.
// One item is in flight at a time; busy drops in the cycle the result is shown.
// Every level memory has a registered read, addressed ahead of the token that uses it.
// Reset clears control state at once and then runs a clearing pass over
// all LEAVES addresses of every level memory; busy stays high during it.
// csr_active_leaves may be written at any time the block is idle; it
// resets to LEAVES. The receiver cannot stall: results are never held.
module sum_tree_weighted_selector_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_operation,
   input  logic [9:0]                   req_leaf_index,
   input  logic [31:0]                  req_weight,
   input  logic [31:0]                  req_random_fraction,
   input  logic                         csr_we,
   input  logic [10:0]                  csr_active_leaves,
   output logic                         rsp_valid,
   output logic [9:0]                   rsp_selected_index,
   output logic [41:0]                  rsp_total_weight,
   output logic [1:0]                   rsp_status
);
   localparam int L  = stws_pkg::LEVELS;
   localparam int IB = stws_pkg::IDX_BITS;
   localparam int SB = stws_pkg::SUM_BITS;
   localparam int CB = $clog2(stws_pkg::LEAVES + 1);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_LEAF = 3'd2;
   localparam logic [2:0] S_MUL1 = 3'd3;
   localparam logic [2:0] S_MUL2 = 3'd4;
   localparam logic [2:0] S_RUN  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [stws_pkg::ACT_BITS-1:0] act_ff;
   logic op_ff;
   stws_pkg::idx_type idx_ff;
   logic [31:0] w_ff, u_ff;
   stws_pkg::sum_type root_ff;
   stws_pkg::sum_type leaf_mem [stws_pkg::LEAVES];
   stws_pkg::sum_type leaf_rd_ff;
   logic [53:0] plo_ff;
   logic [53:0] phi_ff;
   stws_pkg::sum_type r_ff;
   logic rsp_valid_ff;
   stws_pkg::idx_type rsp_idx_ff;
   stws_pkg::sum_type rsp_tot_ff;
   logic [1:0] rsp_st_ff;

   logic clr_en;
   stws_pkg::idx_type clr_addr;
   logic [stws_pkg::ACT_BITS-1:0] usable;
   logic set_bad;
   stws_pkg::sum_type diff;

   stws_pkg::tok_type tok_head;
   stws_pkg::tok_type chain [L+1];
   stws_pkg::tok_type nxt [L+1];

   assign clr_en   = (state_ff == S_CLR);
   assign clr_addr = cnt_ff[IB-1:0];
   assign busy     = (state_ff != S_IDLE);
   assign usable   = (act_ff > stws_pkg::ACT_BITS'(stws_pkg::LEAVES))
                   ? stws_pkg::ACT_BITS'(stws_pkg::LEAVES) : act_ff;
   assign set_bad  = {1'b0, req_leaf_index} >= usable;
   assign diff     = SB'(w_ff) - leaf_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= stws_pkg::ACT_BITS'(stws_pkg::LEAVES);
      end else if (csr_we) begin
         act_ff <= csr_active_leaves;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_CLR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CB'(stws_pkg::LEAVES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cnt_in = '0;
               if (req_operation == stws_pkg::OP_SET) begin
                  state_in = set_bad ? S_RUN : S_LEAF;
               end else begin
                  state_in = (root_ff == '0) ? S_RUN : S_MUL1;
               end
            end
         end
         S_LEAF: state_in = S_RUN;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_RUN;
         S_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CB'(L + 1)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   logic bad_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff  <= req_operation;
         idx_ff <= req_leaf_index;
         w_ff   <= req_weight;
         u_ff   <= req_random_fraction;
         bad_ff <= (req_operation == stws_pkg::OP_SET) ? set_bad : (root_ff == '0);
      end
      leaf_rd_ff <= leaf_mem[req_leaf_index];
      if (clr_en) begin
         leaf_mem[clr_addr] <= '0;
      end else if (state_ff == S_LEAF) begin
         leaf_mem[idx_ff] <= SB'(w_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else if (state_ff == S_LEAF) begin
         root_ff <= root_ff + diff;
      end
   end

   // (2u+1)*total >> 33 split into two 33x21 products of the total
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL1) begin
         plo_ff <= 54'({u_ff, 1'b1}) * 54'(root_ff[20:0]);
         phi_ff <= 54'({u_ff, 1'b1}) * 54'(root_ff[41:21]);
      end
   end

   logic [75:0] full;
   assign full = 76'(phi_ff) * 76'(1 << 21) + 76'(plo_ff);

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL2) begin
         r_ff <= full[74:33];
      end
   end

   logic head_v;
   stws_pkg::sum_type diff_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_LEAF) begin
         diff_ff <= diff;
      end
   end

   always_comb begin
      head_v         = (state_ff == S_RUN) && (cnt_ff == '0) && !bad_ff;
      tok_head.valid = head_v;
      tok_head.op    = op_ff;
      tok_head.node  = '0;
      tok_head.rest  = (op_ff == stws_pkg::OP_SET) ? idx_ff : '0;
      tok_head.val   = (op_ff == stws_pkg::OP_SET) ? diff_ff : r_ff;
   end

   assign chain[0] = tok_head;
   assign nxt[0]   = tok_head;
   for (genvar g = 1; g <= L; g++) begin : g_lvl
      logic              ram_we;
      stws_pkg::idx_type ram_waddr, ram_raddr;
      stws_pkg::sum_type ram_wdata, ram_rdata;

      stws_sel_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .clr_en    (clr_en),
         .clr_addr  (clr_addr),
         .ahead     (nxt[g-1]),
         .tok_in    (chain[g-1]),
         .tok_out   (chain[g]),
         .nxt       (nxt[g]),
         .ram_we    (ram_we),
         .ram_waddr (ram_waddr),
         .ram_wdata (ram_wdata),
         .ram_raddr (ram_raddr),
         .ram_rdata (ram_rdata)
      );

      stws_level_cell #(.LVL(g)) u_sums (
         .clock   (clock),
         .wr_en   (ram_we),
         .wr_addr (ram_waddr),
         .wr_data (ram_wdata),
         .rd_addr (ram_raddr),
         .rd_data (ram_rdata)
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_RUN) && (cnt_ff == CB'(L + 1));
      end
      if ((state_ff == S_RUN) && (cnt_ff == CB'(L + 1))) begin
         rsp_tot_ff <= root_ff;
         if (op_ff == stws_pkg::OP_SET) begin
            rsp_idx_ff <= '0;
            rsp_st_ff  <= bad_ff ? stws_pkg::ST_RANGE : stws_pkg::ST_OK;
         end else if (bad_ff) begin
            rsp_idx_ff <= '0;
            rsp_st_ff  <= stws_pkg::ST_ZERO;
         end else begin
            rsp_idx_ff <= chain[L].node;
            rsp_st_ff  <= ({1'b0, chain[L].node} >= act_ff)
                        ? stws_pkg::ST_BEYOND : stws_pkg::ST_OK;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_index = rsp_idx_ff;
   assign rsp_total_weight   = rsp_tot_ff;
   assign rsp_status         = rsp_st_ff;

   a_busy_clr: assert property (@(posedge clock) disable iff (reset)
      clr_en |-> busy) else $error("clear pass without busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back results");
   a_set_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == stws_pkg::ST_RANGE) |-> rsp_selected_index == '0)
      else $error("range error with index");
   a_leaf_hold: assert property (@(posedge clock) disable iff (reset)
      chain[L].valid |-> chain[L].node == $past(nxt[L].node))
      else $error("leaf token lost its node");
endmodule

// File: rtl/stws_level_cell.sv
// Partial sums of one tree level: a memory with one write port and a registered read.
// Depends on stws_pkg. Written and read by the stws_sel_cell of the same level.
module stws_level_cell #(
   parameter int LVL = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  stws_pkg::idx_type wr_addr,
   input  stws_pkg::sum_type wr_data,
   input  stws_pkg::idx_type rd_addr,
   output stws_pkg::sum_type rd_data
);
   localparam int DEPTH = 1 << LVL;

   stws_pkg::sum_type mem [DEPTH];
   stws_pkg::sum_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[LVL-1:0]] <= wr_data;
      end
      rd_ff <= mem[rd_addr[LVL-1:0]];
   end

   assign rd_data = rd_ff;
endmodule

// File: rtl/stws_sel_cell.sv
// One tree level step: adds a set difference on its node or takes one descent step.
// Depends on stws_pkg; the level's sums sit in a stws_level_cell wired by the top level.
module stws_sel_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              clr_en,
   input  stws_pkg::idx_type clr_addr,
   input  stws_pkg::tok_type ahead,
   input  stws_pkg::tok_type tok_in,
   output stws_pkg::tok_type tok_out,
   output stws_pkg::tok_type nxt,
   output logic              ram_we,
   output stws_pkg::idx_type ram_waddr,
   output stws_pkg::sum_type ram_wdata,
   output stws_pkg::idx_type ram_raddr,
   input  stws_pkg::sum_type ram_rdata
);
   localparam int IB = stws_pkg::IDX_BITS;

   stws_pkg::tok_type tok_ff, tok_in_n;
   stws_pkg::idx_type addr;
   logic rd_bit, wr_bit, go_right;

   // read ahead for the token the previous cell hands over next
   assign rd_bit    = (ahead.op == stws_pkg::OP_SET) ? ahead.rest[IB-1] : 1'b0;
   assign ram_raddr = {ahead.node[IB-2:0], rd_bit};
   assign wr_bit    = (tok_in.op == stws_pkg::OP_SET) ? tok_in.rest[IB-1] : 1'b0;
   assign addr      = {tok_in.node[IB-2:0], wr_bit};
   assign go_right  = tok_in.val > ram_rdata;

   assign ram_we    = clr_en || (tok_in.valid && tok_in.op == stws_pkg::OP_SET);
   assign ram_waddr = clr_en ? clr_addr : addr;
   assign ram_wdata = clr_en ? '0 : ram_rdata + tok_in.val;

   always_comb begin
      tok_in_n      = tok_in;
      tok_in_n.rest = {tok_in.rest[IB-2:0], 1'b0};
      tok_in_n.node = addr;
      if (tok_in.op == stws_pkg::OP_SELECT) begin
         tok_in_n.node = {tok_in.node[IB-2:0], go_right};
         if (go_right) begin
            tok_in_n.val = tok_in.val - ram_rdata;
         end
      end
   end

   assign nxt = tok_in_n;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.op   <= tok_in_n.op;
      tok_ff.node <= tok_in_n.node;
      tok_ff.rest <= tok_in_n.rest;
      tok_ff.val  <= tok_in_n.val;
   end

   assign tok_out = tok_ff;
endmodule
